@@ rtl/core/merge_sort_engine_defines.svh @@
// Assertion macros used by the merge sort engine datapath.
// Each macro wraps one clocked concurrent assertion that is disabled while reset is high.
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MSE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define MSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MSE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define MSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/mse_pkg.sv @@
package mse_pkg;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS_CHK,
    S_RUN_CHK,
    S_RUN_B,
    S_MERGE,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic sort_init;
    logic pass_next;
    logic run_start;
    logic fetch_b;
    logic merge_step;
    logic run_next;
    logic emit_init;
    logic emit_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sort_done;
    logic runs_done;
    logic run_last;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/mse_ram.sv @@
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/mse_datapath.sv @@
`include "merge_sort_engine_defines.svh"

module mse_datapath import mse_pkg::*; #(
  parameter int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int SW = CW + 2
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sorted_value,
  output logic               end_of_run,
  output logic               overflowed
);

  // Control state
  logic [CW-1:0] count;
  logic          ovf;

  // Sort bookkeeping
  logic          src;
  logic [SW-1:0] width;
  logic [CW-1:0] lo;
  logic [CW-1:0] mid;
  logic [CW-1:0] hi;
  logic [CW-1:0] a_ptr;
  logic [CW-1:0] b_ptr;
  logic [CW-1:0] k;
  logic [AW-1:0] idx;
  logic signed [31:0] a_val;
  logic signed [31:0] b_val;
  logic          fresh_a;
  logic          fresh_b;

  // Memory ports
  logic          ram0_we;
  logic          ram1_we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rd0;
  logic [31:0]   rd1;
  logic signed [31:0] rd;

  // Combinational helpers
  logic          full;
  logic [SW-1:0] n_w;
  logic [SW-1:0] mid_sum;
  logic [SW-1:0] hi_sum;
  logic [CW-1:0] mid_c;
  logic [CW-1:0] hi_c;
  logic signed [31:0] a_cur;
  logic signed [31:0] b_cur;
  logic          a_has;
  logic          b_has;
  logic          take_a;
  logic signed [31:0] merge_d;
  logic [CW-1:0] a_inc;
  logic [CW-1:0] b_inc;

  assign full = (count == CW'(CAPACITY));
  assign n_w  = SW'(count);

  // Run bounds for the run that starts at lo
  assign mid_sum = SW'(lo) + width;
  assign hi_sum  = SW'(lo) + (width << 1);
  assign mid_c   = (mid_sum >= n_w) ? count : mid_sum[CW-1:0];
  assign hi_c    = (hi_sum >= n_w) ? count : hi_sum[CW-1:0];

  // Read data of the current source buffer
  assign rd = src ? $signed(rd1) : $signed(rd0);

  // Merge compare; a freshly read head comes straight from the RAM
  assign a_cur   = fresh_a ? rd : a_val;
  assign b_cur   = fresh_b ? rd : b_val;
  assign a_has   = (a_ptr < mid);
  assign b_has   = (b_ptr < hi);
  assign take_a  = a_has && (!b_has || (a_cur <= b_cur));
  assign merge_d = take_a ? a_cur : b_cur;
  assign a_inc   = a_ptr + CW'(1);
  assign b_inc   = b_ptr + CW'(1);

  // Read address select
  always_comb begin
    priority if (cmd.run_start) begin
      raddr = lo[AW-1:0];
    end else if (cmd.fetch_b) begin
      raddr = b_ptr[AW-1:0];
    end else if (cmd.merge_step) begin
      raddr = take_a ? a_inc[AW-1:0] : b_inc[AW-1:0];
    end else begin
      raddr = idx;
    end
  end

  // Write port: loads go to buffer 0, merges to the other buffer
  assign ram0_we = (cmd.load && !full) || (cmd.merge_step && src);
  assign ram1_we = cmd.merge_step && !src;
  assign waddr   = cmd.load ? count[AW-1:0] : k[AW-1:0];
  assign wdata   = cmd.load ? 32'(value) : 32'(merge_d);

  mse_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram0 (
    .clk   (clk),
    .we    (ram0_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd0)
  );

  mse_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram1 (
    .clk   (clk),
    .we    (ram1_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd1)
  );

  // Status to controller
  assign status.sort_done = (width >= n_w);
  assign status.runs_done = (lo >= count);
  assign status.run_last  = ((k + CW'(1)) == hi);
  assign status.emit_last = ((CW'(idx) + CW'(1)) == count);
  assign status.out_free  = !out_valid || out_ready;

  // Count, overflow flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
        if (status.emit_last) begin
          count <= '0;
          ovf   <= 1'b0;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pass, run and merge registers; output payload
  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      width <= SW'(1);
      src   <= 1'b0;
      lo    <= '0;
    end
    if (cmd.pass_next) begin
      width <= width << 1;
      src   <= ~src;
      lo    <= '0;
    end
    if (cmd.run_start) begin
      mid   <= mid_c;
      hi    <= hi_c;
      a_ptr <= lo;
      b_ptr <= mid_c;
      k     <= lo;
    end
    if (cmd.fetch_b) begin
      a_val   <= rd;
      fresh_a <= 1'b0;
      fresh_b <= 1'b1;
    end
    if (cmd.merge_step) begin
      a_val   <= a_cur;
      b_val   <= b_cur;
      fresh_a <= take_a;
      fresh_b <= !take_a;
      k       <= k + CW'(1);
      if (take_a) begin
        a_ptr <= a_inc;
      end else begin
        b_ptr <= b_inc;
      end
    end
    if (cmd.run_next) begin
      lo <= hi;
    end
    if (cmd.emit_init) begin
      idx <= '0;
    end
    if (cmd.emit_load) begin
      idx          <= idx + AW'(1);
      sorted_value <= rd;
      end_of_run   <= status.emit_last;
      overflowed   <= ovf;
    end
  end

  // Checks
  `MSE_ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, count <= CW'(CAPACITY), "count above capacity")
  `MSE_ASSERT_IMPL(a_merge_in_run, clk, rst, cmd.merge_step, (k < hi) && (a_has || b_has), "merge step outside run")
  `MSE_ASSERT_IMPL(a_emit_room, clk, rst, cmd.emit_load, !out_valid || out_ready, "output overwritten")
  `MSE_ASSERT_NEXT(a_clear_after_set, clk, rst, cmd.emit_load && status.emit_last, (count == '0) && !ovf, "data set state not cleared")

endmodule

@@ rtl/core/mse_ctrl.sv @@
module mse_ctrl import mse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    final_item,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && final_item) state_next = S_PASS_CHK;
      end
      S_PASS_CHK: begin
        state_next = status.sort_done ? S_EMIT_RD : S_RUN_CHK;
      end
      S_RUN_CHK: begin
        state_next = status.runs_done ? S_PASS_CHK : S_RUN_B;
      end
      S_RUN_B: begin
        state_next = S_MERGE;
      end
      S_MERGE: begin
        if (status.run_last) state_next = S_RUN_CHK;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (status.out_free) state_next = status.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load      = in_valid;
        cmd.sort_init = in_valid && final_item;
      end
      S_PASS_CHK: begin
        cmd.emit_init = status.sort_done;
      end
      S_RUN_CHK: begin
        cmd.pass_next = status.runs_done;
        cmd.run_start = !status.runs_done;
      end
      S_RUN_B: begin
        cmd.fetch_b = 1'b1;
      end
      S_MERGE: begin
        cmd.merge_step = 1'b1;
        cmd.run_next   = status.run_last;
      end
      S_EMIT_RD: begin
        cmd = '0;
      end
      S_EMIT_LD: begin
        cmd.emit_load = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/merge_sort_engine.sv @@
// Merge sort engine.
// Input channel (in_valid/in_ready, value, final_item): one signed 32-bit value
// per item. Items are taken one per cycle while the block is collecting. The
// item with final_item set closes the data set and starts the sort; items past
// CAPACITY are dropped and raise the overflow flag.
// Sort: bottom-up merge passes between two buffer RAMs, one element written per
// cycle through the single write port, plus the RUN_CHK and RUN_B states to open
// each run and the PASS_CHK state and a closing RUN_CHK visit per pass.
// Output channel (out_valid/out_ready, sorted_value, end_of_run, overflowed):
// values in ascending order, ties in arrival order, end_of_run on the last one,
// overflowed on every item of a set that lost items. Each result goes through a
// RAM read, then an output register load.
// If the receiver stalls, the output register holds its item and emission
// waits; new input is taken once the last result is in the output register.
// Reset (rst, synchronous) empties the buffer, clears the overflow flag and
// drops any item in the output register. Buffer contents need no reset.
module merge_sort_engine import mse_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  input  logic               final_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sorted_value,
  output logic               end_of_run,
  output logic               overflowed
);

  cmd_t    cmd;
  status_t status;

  mse_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .final_item (final_item),
    .status     (status),
    .cmd        (cmd)
  );

  mse_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .end_of_run   (end_of_run),
    .overflowed   (overflowed)
  );

endmodule

@@ dv/testbench.sv @@
module testbench;

  localparam int CAPACITY     = 64;
  localparam int ITEM_TARGET  = 450;
  localparam int HOLD_CYCLES  = 700;
  localparam int TAIL_CYCLES  = 2000;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int MAX_PRINTED  = 100;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  // One sorted result as it should leave the block
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_run;
    logic               overflowed;
  } sorted_item_t;

  // Tracks the set being collected and the sorted items still owed by the block
  class sort_scoreboard;
    logic signed [31:0] held[$];
    bit                 dropped;
    sorted_item_t       owed[$];

    // Accepted input item: buffer it, or drop it when full; a final item sorts the set
    function void note_item(logic signed [31:0] v, bit last);
      logic signed [31:0] ordered[$];
      logic signed [31:0] key;
      sorted_item_t       res;
      int                 j;
      if (held.size() < CAPACITY) held.push_back(v);
      else dropped = 1;
      if (!last) return;
      // stable insertion sort, ascending
      ordered = held;
      for (int i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      foreach (ordered[i]) begin
        res.sorted_value = ordered[i];
        res.end_of_run   = (i == ordered.size() - 1);
        res.overflowed   = dropped;
        owed.push_back(res);
      end
      held.delete();
      dropped = 0;
    endfunction

    // Compare one emitted item against the oldest owed one, field by field
    function bit check_result(logic signed [31:0] v, logic eor, logic ovf,
                              output string why);
      sorted_item_t exp_item;
      why = "";
      if (owed.size() == 0) begin
        why = $sformatf("unexpected item value=%0d end_of_run=%0b overflowed=%0b",
                        v, eor, ovf);
        return 0;
      end
      exp_item = owed.pop_front();
      if (v !== exp_item.sorted_value)
        why = {why, $sformatf(" sorted_value got %0d want %0d", v, exp_item.sorted_value)};
      if (eor !== exp_item.end_of_run)
        why = {why, $sformatf(" end_of_run got %0b want %0b", eor, exp_item.end_of_run)};
      if (ovf !== exp_item.overflowed)
        why = {why, $sformatf(" overflowed got %0b want %0b", ovf, exp_item.overflowed)};
      return (why == "");
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] value;
  logic               final_item;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] sorted_value;
  logic               end_of_run;
  logic               overflowed;

  sort_scoreboard sb = new();
  int  errors       = 0;
  int  results_seen = 0;
  int  items_sent   = 0;
  bit  burst        = 0;
  bit  held_off     = 0;

  merge_sort_engine #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .final_item   (final_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .end_of_run   (end_of_run),
    .overflowed   (overflowed)
  );

  // Clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("merge_sort_engine verification failed");
    $finish;
  end

  task automatic report(input string why);
    errors++;
    if (errors <= MAX_PRINTED) $display("MISMATCH @%0t:%s", $time, why);
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Element values: full range, narrow range for ties, and the extremes
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      6, 7:    return $signed($urandom_range(0, 15)) - 8;
      8: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return 0;
          default: return -1;
        endcase
      end
      9:       return $urandom_range(0, 1) ? VAL_MAX - $urandom_range(0, 3)
                                           : VAL_MIN + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item, called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic signed [31:0] v, input logic last);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1;
    value      <= v;
    final_item <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(v, last);
    items_sent++;
    @(negedge clk);
  endtask

  // One data set of n items with random content
  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
  endtask

  // Sender: reset, directed sets, then random sets
  initial begin
    int n;
    int r;
    int set_idx;
    rst        = 1;
    in_valid   = 0;
    value      = 0;
    final_item = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // single element set
    send_item(32'sd5, 1);
    // extremes with ties
    send_item(VAL_MAX, 0);
    send_item(VAL_MIN, 0);
    send_item(0, 0);
    send_item(-1, 0);
    send_item(1, 0);
    send_item(VAL_MAX, 0);
    send_item(VAL_MIN, 1);
    // descending order
    for (int i = 3; i >= -2; i--) send_item(i, i == -2);
    // all equal
    send_item(7, 0);
    send_item(7, 0);
    send_item(7, 1);

    // random sets: first a full buffer, then one that overflows with its final dropped
    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 19);
      if (set_idx == 0)      n = CAPACITY;
      else if (set_idx == 1) n = CAPACITY + 2;
      else if (r == 0)       n = CAPACITY;
      else if (r == 1)       n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
      else if (r < 4)        n = $urandom_range(17, CAPACITY - 1);
      else                   n = $urandom_range(1, 12);
      burst = ($urandom_range(0, 3) == 0);
      send_set(n);
      set_idx++;
    end
    burst = 0;
    in_valid <= 0;

    // drain, then watch for stray items
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("merge_sort_engine verification clean");
    else $display("merge_sort_engine verification failed");
    $finish;
  end

  // Receiver: random ready pattern, one long hold-off once the run is under way
  initial begin
    int g;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_off && results_seen >= 80) begin
        held_off = 1;
        out_ready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= 1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
        else repeat ($urandom_range(1, 8)) @(negedge clk);
        g = pick_gap();
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) @(negedge clk);
        end
      end
    end
  end

  // Output monitor
  always @(posedge clk) begin : result_monitor
    string why;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (!sb.check_result(sorted_value, end_of_run, overflowed, why)) report(why);
    end
  end

endmodule

@@ merge_sort_engine.f @@
+incdir+rtl/core
rtl/core/mse_pkg.sv
rtl/core/mse_ram.sv
rtl/core/mse_datapath.sv
rtl/core/mse_ctrl.sv
rtl/core/merge_sort_engine.sv
dv/testbench.sv
